// ===== sv/ksfc_pkg.sv =====
`default_nettype none
package ksfc_pkg;
  localparam int NODE_BITS = 10;
  localparam int MAX_NODES = 1024;
  localparam int EDGE_BITS = 12;
  localparam int MAX_EDGES = 4096;
  localparam int WEIGHT_BITS = 16;
  localparam int CNT_BITS = 11;
  localparam int TOTAL_BITS = 13;
  localparam int COST_BITS = 26;
  localparam int RANK_BITS = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_BITS = 2;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic [NODE_BITS-1:0]   a;
    logic [NODE_BITS-1:0]   b;
    logic                   last;
  } edge_item_t;

  typedef struct packed {
    logic [COST_BITS-1:0] total_cost;
    logic [NODE_BITS-1:0] edges_taken;
    logic                 target_reached;
    logic                 edge_overflow;
  } result_t;
endpackage
`default_nettype wire

// ===== sv/ksfc_front.sv =====
`default_nettype none
// input queue: holds incoming edges until the back end drains them
module ksfc_front import ksfc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  edge_item_t      push_item,
  output logic            full,
  input  wire logic       pop,
  output edge_item_t      head,
  output logic            not_empty
);
  edge_item_t q [QUEUE_DEPTH];
  logic [QUEUE_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_BITS:0]   count;

  assign full = (count == (QUEUE_BITS+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QUEUE_BITS+1)'(push) - (QUEUE_BITS+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== sv/ksfc_back.sv =====
`default_nettype none
// back end: store edges, merge sort indices, union-find walk
module ksfc_back import ksfc_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  edge_item_t         in_item,
  output logic               in_pop,
  input  wire logic [CNT_BITS-1:0] node_count,
  input  wire logic [CNT_BITS-1:0] target_components,
  output logic               res_valid,
  output result_t            res
);
  localparam logic [4:0] S_LOAD   = 5'd0;
  localparam logic [4:0] S_INIT   = 5'd1;
  localparam logic [4:0] S_SCOPY  = 5'd2;
  localparam logic [4:0] S_PASS   = 5'd3;
  localparam logic [4:0] S_MRD    = 5'd4;
  localparam logic [4:0] S_MWT    = 5'd5;
  localparam logic [4:0] S_MCMP   = 5'd6;
  localparam logic [4:0] S_PEND   = 5'd7;
  localparam logic [4:0] S_WRD    = 5'd8;
  localparam logic [4:0] S_WWT    = 5'd9;
  localparam logic [4:0] S_WEDGE  = 5'd10;
  localparam logic [4:0] S_FRD    = 5'd11;
  localparam logic [4:0] S_FWT    = 5'd12;
  localparam logic [4:0] S_FCHK   = 5'd13;
  localparam logic [4:0] S_CRD    = 5'd14;
  localparam logic [4:0] S_CWT    = 5'd15;
  localparam logic [4:0] S_CCHK   = 5'd16;
  localparam logic [4:0] S_UNION  = 5'd17;
  localparam logic [4:0] S_RKWT   = 5'd18;
  localparam logic [4:0] S_LINK   = 5'd19;
  localparam logic [4:0] S_DONE   = 5'd20;

  localparam int EDGE_W = WEIGHT_BITS + 2*NODE_BITS;

  logic [4:0] state;

  // edge memory
  logic [EDGE_W-1:0] emem [MAX_EDGES];
  logic [EDGE_BITS-1:0] e_raddr;
  logic [EDGE_W-1:0] e_rdata;
  // two index buffers, ping-pong by pass
  logic [EDGE_BITS-1:0] ib0 [MAX_EDGES];
  logic [EDGE_BITS-1:0] ib1 [MAX_EDGES];
  logic [EDGE_BITS-1:0] i_raddr, i_waddr, i_wdata, i_rdata0, i_rdata1;
  logic i_we;
  logic src;
  // union-find tables
  logic [NODE_BITS-1:0] par [MAX_NODES];
  logic [RANK_BITS-1:0] rnk [MAX_NODES];
  logic [NODE_BITS-1:0] p_raddr, p_waddr, p_wdata, p_rdata;
  logic p_we;
  logic [NODE_BITS-1:0] r_raddr, r_waddr;
  logic [RANK_BITS-1:0] r_wdata, r_rdata;
  logic r_we;

  logic [TOTAL_BITS-1:0] etotal;
  logic ovf;
  logic [TOTAL_BITS-1:0] width, lo, mid, hi, p, q, k, idx;
  logic [WEIGHT_BITS-1:0] wp;
  logic phase;
  logic [NODE_BITS:0] init_cnt;
  logic [CNT_BITS-1:0] need, remain;
  logic [NODE_BITS-1:0] ea, eb, cur, root, ra;
  logic [WEIGHT_BITS-1:0] ew;
  logic side;
  logic [RANK_BITS-1:0] rka;
  logic [COST_BITS-1:0] cost;
  logic [NODE_BITS-1:0] taken;

  // head index words of p and q, captured as rdata passes
  logic [EDGE_BITS-1:0] hp, hq;
  logic [EDGE_BITS-1:0] i_wdata_m;
  logic take_q;
  logic p_ok, q_ok;

  logic [CNT_BITS-1:0] n_lim_v;
  assign n_lim_v = (node_count > CNT_BITS'(MAX_NODES)) ? CNT_BITS'(MAX_NODES)
                                                      : node_count;

  logic [EDGE_BITS-1:0] i_rdata;
  assign i_rdata = src ? i_rdata1 : i_rdata0;
  assign in_pop = (state == S_LOAD) && in_valid;

  logic [TOTAL_BITS-1:0] mid_c, hi_c, lo_w2;
  always_comb begin
    lo_w2 = lo + width;
    mid_c = (lo_w2 > etotal) ? etotal : lo_w2;
    hi_c = ((lo_w2 + width) > etotal) ? etotal : (lo_w2 + width);
  end

  always_ff @(posedge clk) begin
    if (in_pop && etotal < TOTAL_BITS'(MAX_EDGES))
      emem[etotal[EDGE_BITS-1:0]] <= {in_item.weight, in_item.a, in_item.b};
    e_rdata <= emem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (i_we && !src) ib1[i_waddr] <= i_wdata;
    if (i_we && src)  ib0[i_waddr] <= i_wdata;
    i_rdata0 <= ib0[i_raddr];
    i_rdata1 <= ib1[i_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) par[p_waddr] <= p_wdata;
    p_rdata <= par[p_raddr];
    if (r_we) rnk[r_waddr] <= r_wdata;
    r_rdata <= rnk[r_raddr];
  end

  // memory control from registered state
  always_comb begin
    e_raddr = '0; i_raddr = '0; i_waddr = '0; i_wdata = '0; i_we = 1'b0;
    p_raddr = '0; p_waddr = '0; p_wdata = '0; p_we = 1'b0;
    r_raddr = '0; r_waddr = '0; r_wdata = '0; r_we = 1'b0;
    unique case (state)
      S_INIT: begin
        p_we = 1'b1; p_waddr = init_cnt[NODE_BITS-1:0];
        p_wdata = init_cnt[NODE_BITS-1:0];
        r_we = 1'b1; r_waddr = init_cnt[NODE_BITS-1:0];
      end
      S_SCOPY: begin
        // seed identity order into buffer 0 (src=1 writes ib0)
        i_we = 1'b1; i_waddr = k[EDGE_BITS-1:0]; i_wdata = k[EDGE_BITS-1:0];
      end
      S_MRD: begin
        i_raddr = phase ? q[EDGE_BITS-1:0] : p[EDGE_BITS-1:0];
      end
      S_MWT: begin
        e_raddr = i_rdata;
      end
      S_MCMP: begin
        i_we = phase; i_waddr = k[EDGE_BITS-1:0]; i_wdata = i_wdata_m;
      end
      S_WRD: i_raddr = idx[EDGE_BITS-1:0];
      S_WWT: e_raddr = i_rdata;
      S_FRD, S_FWT: p_raddr = cur;
      S_CRD, S_CWT: p_raddr = cur;
      S_CCHK: begin
        p_we = 1'b1; p_waddr = cur; p_wdata = root;
      end
      S_UNION: begin
        r_raddr = ra;
      end
      S_RKWT: r_raddr = root;
      S_LINK: begin
        p_we = 1'b1;
        if (rka < r_rdata) begin
          p_waddr = ra; p_wdata = root;
        end else begin
          p_waddr = root; p_wdata = ra;
          if (rka == r_rdata) begin
            r_we = 1'b1; r_waddr = ra; r_wdata = rka + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // merge bookkeeping: p and q walk the two halves of the current segment
  assign p_ok = (p < mid);
  assign q_ok = (q < hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      etotal <= '0;
      ovf <= 1'b0;
      res_valid <= 1'b0;
      src <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      unique case (state)
        S_LOAD: if (in_pop) begin
          if (etotal < TOTAL_BITS'(MAX_EDGES)) etotal <= etotal + 1'b1;
          else ovf <= 1'b1;
          if (in_item.last) begin
            state <= S_INIT;
            init_cnt <= '0;
          end
        end
        S_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == (NODE_BITS+1)'(MAX_NODES-1)) begin
            need <= (target_components >= n_lim_v) ? '0 : n_lim_v - target_components;
            remain <= (target_components >= n_lim_v) ? '0 : n_lim_v - target_components;
            cost <= '0; taken <= '0;
            src <= 1'b1; k <= '0;
            state <= (etotal == '0) ? S_PEND : S_SCOPY;
          end
        end
        S_SCOPY: begin
          k <= k + 1'b1;
          if (k + 1'b1 == etotal) begin
            src <= 1'b0; width <= TOTAL_BITS'(1);
            state <= S_PASS;
          end
        end
        S_PASS: begin
          if (width >= etotal) begin
            idx <= '0; state <= S_WRD;
          end else begin
            lo <= '0;
            state <= S_PEND;
            phase <= 1'b0;
          end
        end
        S_PEND: begin
          if (need == '0 && etotal == '0) state <= S_DONE;
          else if (etotal == '0) state <= S_DONE;
          else if (lo >= etotal) begin
            src <= ~src; width <= {width[TOTAL_BITS-2:0], 1'b0};
            state <= S_PASS;
          end else begin
            mid <= mid_c; hi <= hi_c; p <= lo; q <= mid_c; k <= lo;
            phase <= 1'b0; state <= S_MRD;
          end
        end
        // fetch heads: phase 0 reads p's index, phase 1 reads q's
        S_MRD: state <= S_MWT;
        S_MWT: state <= S_MCMP;
        S_MCMP: begin
          if (!phase) begin
            wp <= e_rdata[EDGE_W-1:2*NODE_BITS];
            phase <= 1'b1; state <= S_MRD;
          end else begin
            if (k + 1'b1 == hi) begin
              lo <= lo + {width[TOTAL_BITS-2:0], 1'b0};
              state <= S_PEND;
            end else state <= S_MRD;
            k <= k + 1'b1;
            if (take_q) q <= q + 1'b1; else p <= p + 1'b1;
            phase <= 1'b0;
          end
        end
        S_WRD: begin
          if (idx >= etotal || remain == '0) state <= S_DONE;
          else state <= S_WWT;
        end
        S_WWT: state <= S_WEDGE;
        S_WEDGE: begin
          {ew, ea, eb} <= e_rdata;
          if ({1'b0, e_rdata[2*NODE_BITS-1:NODE_BITS]} >= n_lim_v ||
              {1'b0, e_rdata[NODE_BITS-1:0]} >= n_lim_v) begin
            idx <= idx + 1'b1; state <= S_WRD;
          end else begin
            cur <= e_rdata[2*NODE_BITS-1:NODE_BITS]; side <= 1'b0;
            state <= S_FRD;
          end
        end
        S_FRD: state <= S_FWT;
        S_FWT: state <= S_FCHK;
        S_FCHK: begin
          if (p_rdata == cur) begin
            root <= cur;
            cur <= side ? eb : ea;
            state <= S_CRD;
          end else begin
            cur <= p_rdata; state <= S_FRD;
          end
        end
        S_CRD: state <= S_CWT;
        S_CWT: state <= S_CCHK;
        S_CCHK: begin
          if (cur == root) begin
            if (!side) begin
              ra <= root; side <= 1'b1; cur <= eb; state <= S_FRD;
            end else if (ra == root) begin
              idx <= idx + 1'b1; state <= S_WRD;
            end else state <= S_UNION;
          end else begin
            cur <= p_rdata; state <= S_CRD;
          end
        end
        S_UNION: state <= S_RKWT;
        S_RKWT: begin
          rka <= r_rdata; state <= S_LINK;
        end
        S_LINK: begin
          cost <= cost + COST_BITS'(ew);
          taken <= taken + 1'b1;
          remain <= remain - 1'b1;
          idx <= idx + 1'b1;
          state <= S_WRD;
        end
        S_DONE: begin
          res_valid <= 1'b1;
          res.total_cost <= cost;
          res.edges_taken <= taken;
          res.target_reached <= (CNT_BITS'(taken) == need);
          res.edge_overflow <= ovf;
          etotal <= '0; ovf <= 1'b0;
          state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MWT) begin
      if (!phase) hp <= i_rdata; else hq <= i_rdata;
    end
  end
  // phase 1 reads q even when !q_ok; q weight then stands unused, as p weight does when !p_ok
  always_comb begin
    take_q = !p_ok || (q_ok && (e_rdata[EDGE_W-1:2*NODE_BITS] < wp));
    i_wdata_m = take_q ? hq : hp;
  end
endmodule
`default_nettype wire

// ===== sv/kruskal_spanning_forest_cost.sv =====
`default_nettype none
// kruskal_spanning_forest_cost: edges are accepted one per cycle; busy stays low
// while a set loads and goes high once the edge with last_edge set is accepted.
// the block then clears the 1024-entry union-find tables, copies the edge
// indices and merge sorts them, with two index and edge reads per merged edge,
// then walks the sorted edges: it follows the find path of each endpoint, then
// compresses that path, and links by rank on each union; the walk ends early
// once enough edges are taken. busy stays high until the single result strobe
// on done; the receiver cannot stall and must take the result in that cycle.
module kruskal_spanning_forest_cost import ksfc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [WEIGHT_BITS-1:0] edge_weight,
  input  wire logic [NODE_BITS-1:0]   node_a,
  input  wire logic [NODE_BITS-1:0]   node_b,
  input  wire logic                   last_edge,
  output logic                        done,
  output logic [COST_BITS-1:0]        total_cost,
  output logic [NODE_BITS-1:0]        edges_taken,
  output logic                        target_reached,
  output logic                        edge_overflow,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  logic [CNT_BITS-1:0] node_count, target_components;
  logic q_full, q_ne, q_pop, sealed;
  edge_item_t push_item, head;
  result_t res;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CNT_BITS'(MAX_NODES);
      target_components <= CNT_BITS'(1);
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'd0) node_count <= pwdata[CNT_BITS-1:0];
      else if (paddr == 3'd4) target_components <= pwdata[CNT_BITS-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == 3'd0) prdata = 32'(node_count);
    else if (paddr == 3'd4) prdata = 32'(target_components);
  end

  // once a last edge enters the queue, hold off until the result goes out
  assign busy = q_full || sealed;
  always_ff @(posedge clk) begin
    if (rst) sealed <= 1'b0;
    else if (start && !busy && last_edge) sealed <= 1'b1;
    else if (done) sealed <= 1'b0;
  end

  assign push_item = '{weight: edge_weight, a: node_a, b: node_b, last: last_edge};

  ksfc_front u_front (
    .clk, .rst, .push(start && !busy), .push_item, .full(q_full),
    .pop(q_pop), .head, .not_empty(q_ne)
  );

  ksfc_back u_back (
    .clk, .rst, .in_valid(q_ne), .in_item(head), .in_pop(q_pop),
    .node_count, .target_components, .res_valid(done), .res
  );

  assign total_cost = res.total_cost;
  assign edges_taken = res.edges_taken;
  assign target_reached = res.target_reached;
  assign edge_overflow = res.edge_overflow;
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import ksfc_pkg::*;

  localparam int REG_NODE_COUNT = 0;
  localparam int REG_TARGET     = 1;
  localparam int STALL_LIMIT    = 1500000;
  localparam int RAND_ITEMS     = 900;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [WEIGHT_BITS-1:0] edge_weight = '0;
  logic [NODE_BITS-1:0]   node_a = '0;
  logic [NODE_BITS-1:0]   node_b = '0;
  logic                   last_edge = 1'b0;
  logic                   done;
  logic [COST_BITS-1:0]   total_cost;
  logic [NODE_BITS-1:0]   edges_taken;
  logic                   target_reached;
  logic                   edge_overflow;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [2:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  kruskal_spanning_forest_cost i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .edge_weight(edge_weight), .node_a(node_a), .node_b(node_b), .last_edge(last_edge),
    .done(done), .total_cost(total_cost), .edges_taken(edges_taken),
    .target_reached(target_reached), .edge_overflow(edge_overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  edge_item_t pend_edges[$];
  result_t    forest_q[$];

  // predictor state
  logic [10:0]            cfg_nodes = 11'd1024;
  logic [10:0]            cfg_target = 11'd1;
  logic [WEIGHT_BITS-1:0] st_w[MAX_EDGES];
  logic [NODE_BITS-1:0]   st_a[MAX_EDGES];
  logic [NODE_BITS-1:0]   st_b[MAX_EDGES];
  int                     st_cnt = 0;
  bit                     st_ovf = 1'b0;
  int                     order[MAX_EDGES];
  int                     uf_par[MAX_NODES];
  int                     uf_rank[MAX_NODES];

  int  n_items = 0;
  int  n_sets = 0;
  int  n_ovf_sets = 0;
  int  n_err = 0;
  int  stall = 0;
  int  gap = 0;
  bit  idle_on = 1'b1;
  bit  took;

  function automatic int uf_find(int x);
    int r;
    int nxt;
    r = x;
    while (uf_par[r] != r) r = uf_par[r];
    while (uf_par[x] != r) begin
      nxt = uf_par[x];
      uf_par[x] = r;
      x = nxt;
    end
    return r;
  endfunction

  function automatic result_t forest_cost();
    result_t res;
    int n, need, taken, i, j, key, ra, rb;
    logic [COST_BITS-1:0] cost;
    n = (cfg_nodes > MAX_NODES) ? MAX_NODES : cfg_nodes;
    need = (cfg_target >= n) ? 0 : n - cfg_target;
    for (i = 0; i < MAX_NODES; i++) begin
      uf_par[i] = i;
      uf_rank[i] = 0;
    end
    // stable insertion sort by weight
    for (i = 0; i < st_cnt; i++) begin
      key = i;
      j = i - 1;
      while (j >= 0 && st_w[order[j]] > st_w[key]) begin
        order[j+1] = order[j];
        j--;
      end
      order[j+1] = key;
    end
    cost = '0;
    taken = 0;
    for (i = 0; i < st_cnt && taken < need; i++) begin
      key = order[i];
      if (st_a[key] >= n || st_b[key] >= n) continue;
      ra = uf_find(st_a[key]);
      rb = uf_find(st_b[key]);
      if (ra == rb) continue;
      if (uf_rank[ra] < uf_rank[rb]) uf_par[ra] = rb;
      else begin
        uf_par[rb] = ra;
        if (uf_rank[ra] == uf_rank[rb]) uf_rank[ra]++;
      end
      cost += st_w[key];
      taken++;
    end
    res.total_cost = cost;
    res.edges_taken = taken[NODE_BITS-1:0];
    res.target_reached = (taken == need);
    res.edge_overflow = st_ovf;
    return res;
  endfunction

  function automatic void load_edge(edge_item_t it);
    if (st_cnt < MAX_EDGES) begin
      st_w[st_cnt] = it.weight;
      st_a[st_cnt] = it.a;
      st_b[st_cnt] = it.b;
      st_cnt++;
    end else st_ovf = 1'b1;
    if (it.last) begin
      forest_q.push_back(forest_cost());
      if (st_ovf) n_ovf_sets++;
      n_sets++;
      st_cnt = 0;
      st_ovf = 1'b0;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        load_edge(pend_edges[0]);
        void'(pend_edges.pop_front());
        n_items++;
      end
      if (start && !took) begin
        // hold the item until the transfer
      end else if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (pend_edges.size() > 0) begin
        if (idle_on && $urandom_range(0, 9) == 0) begin
          gap = $urandom_range(0, 6);
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          edge_weight <= pend_edges[0].weight;
          node_a <= pend_edges[0].a;
          node_b <= pend_edges[0].b;
          last_edge <= pend_edges[0].last;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (forest_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result cost=%0d taken=%0d", total_cost,
                                    edges_taken);
        end else begin
          if (total_cost !== forest_q[0].total_cost ||
              edges_taken !== forest_q[0].edges_taken ||
              target_reached !== forest_q[0].target_reached ||
              edge_overflow !== forest_q[0].edge_overflow) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch set %0d: exp cost=%0d taken=%0d reached=%0d ovf=%0d, got cost=%0d taken=%0d reached=%0d ovf=%0d",
                       n_sets, forest_q[0].total_cost, forest_q[0].edges_taken,
                       forest_q[0].target_reached, forest_q[0].edge_overflow,
                       total_cost, edges_taken, target_reached, edge_overflow);
          end
          void'(forest_q.pop_front());
        end
      end
      if ((start && !busy) || done || psel) stall <= 0;
      else if (stall >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", stall);
        $display("[FAIL] regression broken");
        $finish;
      end else stall <= stall + 1;
    end
  end

  task automatic cfg_write(int idx, logic [10:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * idx);
    pwdata <= {21'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_NODE_COUNT) cfg_nodes = val;
    else cfg_target = val;
  endtask

  task automatic set_cfg(logic [10:0] nc, logic [10:0] tc);
    cfg_write(REG_NODE_COUNT, nc);
    cfg_write(REG_TARGET, tc);
  endtask

  task automatic drain();
    while (pend_edges.size() > 0 || forest_q.size() > 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_edge(int w, int a, int b, bit last);
    edge_item_t it;
    it.weight = w[WEIGHT_BITS-1:0];
    it.a = a[NODE_BITS-1:0];
    it.b = b[NODE_BITS-1:0];
    it.last = last;
    pend_edges.push_back(it);
  endtask

  task automatic rand_set(int sz, int n);
    int lim, k, w, a, b, mode;
    lim = (n + 1 > 1023) ? 1023 : n + 1;
    mode = $urandom_range(0, 7);
    for (k = 0; k < sz; k++) begin
      case ($urandom_range(0, 7))
        0, 1, 2: w = $urandom_range(0, 7);
        3:       w = $urandom_range(0, 1) ? 65535 : 0;
        default: w = $urandom_range(0, 65535);
      endcase
      if (mode == 0) begin
        a = $urandom_range(0, 1023);
        b = $urandom_range(0, 1023);
      end else begin
        a = $urandom_range(0, lim);
        b = $urandom_range(0, lim);
      end
      push_edge(w, a, b, k == sz - 1);
    end
  endtask

  initial begin
    int rand_cnt, phase_cnt, sz, nc, tc, k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: max weight, self loop, ties, top node
    push_edge(65535, 1023, 0, 0);
    push_edge(0, 5, 5, 0);
    push_edge(100, 0, 1, 0);
    push_edge(100, 1, 0, 0);
    push_edge(100, 2, 1023, 1);
    drain();
    // small graph with out of range endpoints
    set_cfg(8, 1);
    push_edge(7, 0, 7, 0);
    push_edge(3, 8, 1, 0);
    push_edge(3, 1023, 2, 0);
    push_edge(1, 1, 2, 0);
    push_edge(1, 2, 3, 0);
    push_edge(2, 1, 3, 0);
    push_edge(5, 3, 4, 0);
    push_edge(5, 4, 5, 0);
    push_edge(5, 5, 6, 0);
    push_edge(6, 6, 7, 1);
    drain();
    // target at node count
    set_cfg(4, 4);
    push_edge(10, 0, 1, 1);
    drain();
    // node count clipped, zero target
    set_cfg(2047, 0);
    push_edge(65535, 0, 1, 0);
    push_edge(65535, 1, 2, 1);
    drain();
    set_cfg(1, 1024);
    push_edge(1, 0, 0, 1);
    drain();

    // store overflow, then a set to show the flag clears
    set_cfg(16, 2);
    for (k = 0; k <= MAX_EDGES; k++)
      push_edge($urandom_range(0, 65535), $urandom_range(0, 31), $urandom_range(0, 31),
                k == MAX_EDGES);
    push_edge(3, 0, 1, 1);
    drain();

    rand_cnt = 0;
    while (rand_cnt < RAND_ITEMS) begin
      case ($urandom_range(0, 5))
        0: begin nc = 1024; tc = 1; end
        1: begin nc = $urandom_range(2, 40); tc = 1; end
        2: begin nc = $urandom_range(2, 40); tc = $urandom_range(1, nc + 2); end
        3: begin nc = 1; tc = 1; end
        4: begin nc = $urandom_range(2, 40); tc = 0; end
        default: begin nc = 1024; tc = 1024; end
      endcase
      set_cfg(nc[10:0], tc[10:0]);
      phase_cnt = 0;
      while (phase_cnt < 100 && rand_cnt < RAND_ITEMS) begin
        sz = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 24);
        rand_set(sz, nc);
        phase_cnt += sz;
        rand_cnt += sz;
        if (rand_cnt > 750) idle_on = 1'b0;
      end
      drain();
    end

    repeat (2000) @(posedge clk);
    $display("%0d edges loaded in %0d sets, %0d of them past store capacity", n_items,
             n_sets, n_ovf_sets);
    $display("mismatches: %0d", n_err);
    if (n_err == 0 && forest_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
